[src/mtt_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and token-building functions for the markup text tokenizer.
// No dependencies; every other file of the block imports this package.
package mtt_pkg;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // Tokens one input byte can produce at most
    localparam int MAX_BEATS = 3;

    // Token kinds
    typedef enum logic [2:0] {
        KIND_TEXT_CHAR   = 3'd0,
        KIND_IMAGE_CHAR  = 3'd1,
        KIND_TEXT_END    = 3'd2,
        KIND_IMAGE_END   = 3'd3,
        KIND_GROUP_BEGIN = 3'd4,
        KIND_GROUP_END   = 3'd5,
        KIND_STATUS      = 3'd6
    } tok_kind_t;

    // Status codes
    localparam logic [1:0] CODE_OK              = 2'd0;
    localparam logic [1:0] CODE_EMPTY_IMAGE     = 2'd1;
    localparam logic [1:0] CODE_TRAILING_ESCAPE = 2'd2;

    // Markup characters
    localparam logic [7:0] CH_AT        = 8'h40;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DASH      = 8'h2D;
    localparam logic [7:0] CH_UNDERLINE = 8'h5F;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // Parser state carried from byte to byte
    typedef struct packed {
        logic       image_mode;
        logic       escape_pending;
        logic       run_nonempty;
        logic       failed;
        logic [1:0] fail_code;
    } tok_state_t;

    // One output beat
    typedef struct packed {
        tok_kind_t  kind;
        logic [7:0] ch;
        logic [1:0] code;
        logic       last;
    } tok_beat_t;

    // All beats caused by one input byte, as one queue entry
    typedef struct packed {
        logic [1:0]                    count;
        tok_beat_t [MAX_BEATS-1:0]     beats;
    } tok_entry_t;

    // Working record while one byte is classified
    typedef struct packed {
        tok_state_t st;
        tok_entry_t entry;
    } tok_work_t;

    // Queue status seen by front, back and top
    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

    function automatic logic is_name_byte(logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
            || (c == CH_DASH) || (c == CH_UNDERLINE);
    endfunction

    // Append a beat unconditionally (capped at three)
    function automatic tok_work_t work_put(tok_work_t w, tok_kind_t k, logic [7:0] ch,
                                           logic [1:0] code, logic last);
        tok_work_t r;
        r = w;
        if (r.entry.count != 2'd3)
        begin
            r.entry.beats[r.entry.count].kind = k;
            r.entry.beats[r.entry.count].ch   = ch;
            r.entry.beats[r.entry.count].code = code;
            r.entry.beats[r.entry.count].last = last;
            r.entry.count = r.entry.count + 2'd1;
        end
        return r;
    endfunction

    // Append a token unless an error already stopped output
    function automatic tok_work_t work_token(tok_work_t w, tok_kind_t k, logic [7:0] ch);
        tok_work_t r;
        r = w;
        if (!r.st.failed)
        begin
            r = work_put(r, k, ch, CODE_OK, 1'b0);
        end
        return r;
    endfunction

    // Record the first error only
    function automatic tok_work_t work_set_fail(tok_work_t w, logic [1:0] code);
        tok_work_t r;
        r = w;
        if (!r.st.failed)
        begin
            r.st.failed    = 1'b1;
            r.st.fail_code = code;
        end
        return r;
    endfunction

    // Close the open text or image run
    function automatic tok_work_t work_close_run(tok_work_t w);
        tok_work_t r;
        r = w;
        if (r.st.image_mode)
        begin
            if (r.st.run_nonempty)
                r = work_token(r, KIND_IMAGE_END, 8'h00);
            else
                r = work_set_fail(r, CODE_EMPTY_IMAGE);
        end
        else if (r.st.run_nonempty)
        begin
            r = work_token(r, KIND_TEXT_END, 8'h00);
        end
        r.st.run_nonempty = 1'b0;
        return r;
    endfunction

    // One byte in text mode
    function automatic tok_work_t work_text_byte(tok_work_t w, logic [7:0] c);
        tok_work_t r;
        r = w;
        if (r.st.escape_pending)
        begin
            r = work_token(r, KIND_TEXT_CHAR, c);
            r.st.run_nonempty   = 1'b1;
            r.st.escape_pending = 1'b0;
        end
        else
        begin
            unique case (c)
                CH_AT:
                begin
                    r = work_close_run(r);
                    r.st.image_mode = 1'b1;
                end
                CH_LBRACE:
                begin
                    r = work_close_run(r);
                    r = work_token(r, KIND_GROUP_BEGIN, 8'h00);
                end
                CH_RBRACE:
                begin
                    r = work_close_run(r);
                    r = work_token(r, KIND_GROUP_END, 8'h00);
                end
                CH_BACKSLASH:
                begin
                    r.st.escape_pending = 1'b1;
                end
                default:
                begin
                    r = work_token(r, KIND_TEXT_CHAR, c);
                    r.st.run_nonempty = 1'b1;
                end
            endcase
        end
        return r;
    endfunction

    // Full handling of one input byte: next state plus its beats
    function automatic tok_work_t work_step(tok_state_t st, logic [7:0] c, logic last);
        tok_work_t r;
        r       = '0;
        r.st    = st;
        if (!r.st.failed)
        begin
            if (r.st.image_mode)
            begin
                if (is_name_byte(c))
                begin
                    r = work_token(r, KIND_IMAGE_CHAR, c);
                    r.st.run_nonempty = 1'b1;
                end
                else
                begin
                    r = work_close_run(r);
                    r.st.image_mode = 1'b0;
                    if (c != CH_SPACE)
                        r = work_text_byte(r, c);
                end
            end
            else
            begin
                r = work_text_byte(r, c);
            end
        end
        if (last)
        begin
            if (!r.st.failed)
            begin
                r = work_close_run(r);
                if (!r.st.failed && r.st.escape_pending)
                    r = work_set_fail(r, CODE_TRAILING_ESCAPE);
            end
            r = work_put(r, KIND_STATUS, 8'h00,
                         r.st.failed ? r.st.fail_code : CODE_OK, 1'b1);
            r.st = '0;
        end
        return r;
    endfunction

endpackage

[src/mtt_front.sv]
`timescale 1ns / 1ps
// Front end: accepts input bytes, keeps the parser state and builds the beats of each byte.
// Depends on mtt_pkg.
module mtt_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         char_value,
    input  logic               last_char,
    input  mtt_pkg::q_status_t q_stat,
    output logic               push,
    output mtt_pkg::tok_entry_t push_entry
);
    import mtt_pkg::*;

    tok_state_t state_reg;
    tok_state_t state_next;
    tok_work_t  work;
    logic       accept;

    // Classify the incoming byte against the current state
    always_comb
    begin
        work       = work_step(state_reg, char_value, last_char);
        accept     = in_valid && !q_stat.full;
        in_stall   = q_stat.full;
        push       = accept && (work.entry.count != 2'd0);
        push_entry = work.entry;
        state_next = accept ? work.st : state_reg;
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else
            state_reg <= state_next;
    end

endmodule

[src/mtt_queue.sv]
`timescale 1ns / 1ps
// Show-ahead queue of per-byte beat groups between front and back end.
// Depends on mtt_pkg.
module mtt_queue #(
    parameter int DEPTH = mtt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mtt_pkg::tok_entry_t push_entry,
    input  logic                pop,
    output mtt_pkg::tok_entry_t head,
    output mtt_pkg::q_status_t  q_stat
);
    import mtt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tok_entry_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
        q_stat.full      = (count_reg == CNT_W'(DEPTH));
        q_stat.not_empty = (count_reg != '0);
        head             = mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

[src/mtt_back.sv]
`timescale 1ns / 1ps
// Back end: walks the beats of the head queue entry into the output register.
// Depends on mtt_pkg.
module mtt_back (
    input  logic                clk,
    input  logic                rst_n,
    input  mtt_pkg::tok_entry_t head,
    input  mtt_pkg::q_status_t  q_stat,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output mtt_pkg::tok_beat_t  out_beat
);
    import mtt_pkg::*;

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    tok_beat_t  beat_reg;
    tok_beat_t  beat_next;
    logic       load;
    logic       last_beat;

    // Load the next beat whenever the output register is free
    always_comb
    begin
        load           = !out_valid_reg || !out_stall;
        last_beat      = (idx_reg == (head.count - 2'd1));
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        beat_next      = beat_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = q_stat.not_empty;
            beat_next      = head.beats[idx_reg];
            if (q_stat.not_empty)
            begin
                pop      = last_beat;
                idx_next = last_beat ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload, no reset
    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = beat_reg;

endmodule

[src/markup_text_tokenizer.sv]
`timescale 1ns / 1ps
// Top level of the markup text tokenizer: front end, beat queue, back end.
// Depends on mtt_pkg, mtt_front, mtt_queue and mtt_back.
//
//   channel  handshake            payload
//   -------  -------------------  -------------------------------------------
//   in       in_valid / in_stall  char_value[7:0], last_char
//   out      out_valid/out_stall  kind[2:0], char_out[7:0], status_code[1:0],
//                                 last_of_run
//
// One byte is accepted per cycle while the queue has room; a byte yields
// zero to three beats; the back end sends one beat per cycle unless out_stall
// is high, so the output port sets the sustained rate. Beats pass the queue,
// then the output register. in_stall rises only when the queue (QUEUE_DEPTH
// entries) is full. Reset clears parser state, queue and output valid flag.
module markup_text_tokenizer #(
    parameter int QUEUE_DEPTH = mtt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_value,
    input  logic       last_char,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] kind,
    output logic [7:0] char_out,
    output logic [1:0] status_code,
    output logic       last_of_run
);
    import mtt_pkg::*;

    q_status_t  q_stat;
    logic       q_push;
    logic       q_pop;
    tok_entry_t q_push_entry;
    tok_entry_t q_head;
    tok_beat_t  out_beat;

    mtt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_value (char_value),
        .last_char  (last_char),
        .q_stat     (q_stat),
        .push       (q_push),
        .push_entry (q_push_entry)
    );

    mtt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .head       (q_head),
        .q_stat     (q_stat)
    );

    mtt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_stat    (q_stat),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_beat  (out_beat)
    );

    assign kind        = out_beat.kind;
    assign char_out    = out_beat.ch;
    assign status_code = out_beat.code;
    assign last_of_run = out_beat.last;

    // Only status beats close a string, and only they carry a code
    a_status_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((kind == KIND_STATUS) == last_of_run)
                      && ((kind == KIND_STATUS) || (status_code == CODE_OK)))
        else $error("status fields on a non-status beat");

    // The queue never takes an entry while full, never gives one while empty
    a_queue_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_stat.full) && !(q_pop && !q_stat.not_empty))
        else $error("queue overflow or underflow");

    // A beat can appear only from a queued entry
    a_out_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid && !q_stat.not_empty) |=> !out_valid)
        else $error("output beat without a queued entry");

endmodule

[tb/tb_markup_text_tokenizer.sv]
`timescale 1ns / 1ps
// Self-checking testbench for markup_text_tokenizer: directed and random markup strings.
// Depends on mtt_pkg (token kinds, status codes, markup characters) and the block's RTL.
module tb_markup_text_tokenizer;
    import mtt_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    // Token predictor plus queue of expected beats
    class token_scoreboard;
        logic            in_image;
        logic            escaped;
        logic            run_open;
        logic            stopped;
        logic [1:0]      stop_code;
        int              beats_this_byte;
        int              errors;
        tok_beat_t       pending_tokens[$];

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            in_image  = 1'b0;
            escaped   = 1'b0;
            run_open  = 1'b0;
            stopped   = 1'b0;
            stop_code = CODE_OK;
        endfunction

        // At most MAX_BEATS beats per input byte
        function void push_beat(tok_kind_t k, logic [7:0] c, logic [1:0] code, logic fin);
            tok_beat_t b;
            if (beats_this_byte < MAX_BEATS)
            begin
                b.kind = k;
                b.ch   = c;
                b.code = code;
                b.last = fin;
                pending_tokens.push_back(b);
                beats_this_byte++;
            end
        endfunction

        // Tokens are dropped once the string has failed
        function void push_token(tok_kind_t k, logic [7:0] c);
            if (!stopped)
                push_beat(k, c, CODE_OK, 1'b0);
        endfunction

        function void raise_error(logic [1:0] code);
            if (!stopped)
            begin
                stopped   = 1'b1;
                stop_code = code;
            end
        endfunction

        function void end_run();
            if (in_image)
            begin
                if (run_open)
                    push_token(KIND_IMAGE_END, 8'h00);
                else
                    raise_error(CODE_EMPTY_IMAGE);
            end
            else if (run_open)
            begin
                push_token(KIND_TEXT_END, 8'h00);
            end
            run_open = 1'b0;
        endfunction

        function bit name_char(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")
                || c == CH_DASH || c == CH_UNDERLINE;
        endfunction

        function void text_char(logic [7:0] c);
            if (escaped)
            begin
                push_token(KIND_TEXT_CHAR, c);
                run_open = 1'b1;
                escaped  = 1'b0;
            end
            else if (c == CH_AT)
            begin
                end_run();
                in_image = 1'b1;
            end
            else if (c == CH_LBRACE)
            begin
                end_run();
                push_token(KIND_GROUP_BEGIN, 8'h00);
            end
            else if (c == CH_RBRACE)
            begin
                end_run();
                push_token(KIND_GROUP_END, 8'h00);
            end
            else if (c == CH_BACKSLASH)
            begin
                escaped = 1'b1;
            end
            else
            begin
                push_token(KIND_TEXT_CHAR, c);
                run_open = 1'b1;
            end
        endfunction

        // Note one accepted input beat and queue the tokens it causes
        function void tokenize_byte(logic [7:0] c, logic fin);
            beats_this_byte = 0;
            if (!stopped)
            begin
                if (!in_image)
                begin
                    text_char(c);
                end
                else if (name_char(c))
                begin
                    push_token(KIND_IMAGE_CHAR, c);
                    run_open = 1'b1;
                end
                else
                begin
                    end_run();
                    in_image = 1'b0;
                    if (c != CH_SPACE)
                        text_char(c);
                end
            end
            if (fin)
            begin
                if (!stopped)
                begin
                    end_run();
                    if (!stopped && escaped)
                        raise_error(CODE_TRAILING_ESCAPE);
                end
                push_beat(KIND_STATUS, 8'h00, stopped ? stop_code : CODE_OK, 1'b1);
                restart();
            end
        endfunction

        // Compare one accepted output beat with the oldest expected token
        function void check_token(logic [2:0] k, logic [7:0] c, logic [1:0] code, logic fin);
            tok_beat_t b;
            if (pending_tokens.size() == 0)
            begin
                $error("unexpected beat: kind %0d char_out %0h status_code %0d last_of_run %0b",
                       k, c, code, fin);
                errors++;
                return;
            end
            b = pending_tokens.pop_front();
            if (k !== b.kind)
            begin
                $error("kind: expected %0d, actual %0d", b.kind, k);
                errors++;
            end
            if (c !== b.ch)
            begin
                $error("char_out: expected %0h, actual %0h", b.ch, c);
                errors++;
            end
            if (code !== b.code)
            begin
                $error("status_code: expected %0d, actual %0d", b.code, code);
                errors++;
            end
            if (fin !== b.last)
            begin
                $error("last_of_run: expected %0b, actual %0b", b.last, fin);
                errors++;
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_BYTES   = 400;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic [7:0] char_value  = 8'h00;
    logic       last_char   = 1'b0;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    logic [2:0] kind;
    logic [7:0] char_out;
    logic [1:0] status_code;
    logic       last_of_run;

    int idle_pct   = 0;
    int stall_pct  = 0;
    int bytes_sent = 0;
    int quiet_cycles = 0;

    token_scoreboard sb = new();

    markup_text_tokenizer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .char_value  (char_value),
        .last_char   (last_char),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .char_out    (char_out),
        .status_code (status_code),
        .last_of_run (last_of_run)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver stall
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Output beats
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_token(kind, char_out, status_code, last_of_run);
    end

    // Watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("markup_text_tokenizer verification failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] c, input logic fin);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        char_value <= c;
        last_char  <= fin;
        do
            @(posedge clk);
        while (in_stall);
        sb.tokenize_byte(c, fin);
        bytes_sent++;
    endtask

    task automatic send_string(input byte_q_t s);
        foreach (s[i])
            send_byte(s[i], i == s.size() - 1);
    endtask

    function automatic logic [7:0] pick_name_char();
        int r;
        r = $urandom_range(0, 53);
        if (r < 26)
            return 8'("a" + r);
        else if (r < 52)
            return 8'("A" + r - 26);
        else if (r == 52)
            return CH_DASH;
        return CH_UNDERLINE;
    endfunction

    // Any byte except the markup characters @, {, } and backslash
    function automatic logic [7:0] pick_text_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (c == CH_AT || c == CH_LBRACE || c == CH_RBRACE || c == CH_BACKSLASH);
        return c;
    endfunction

    // Mostly well-formed markup with random content, plus some noise
    function automatic byte_q_t random_markup();
        byte_q_t s;
        int      pick;
        int      n;
        n = $urandom_range(1, 4);
        repeat (n)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                repeat ($urandom_range(1, 4))
                    s.push_back(pick_text_char());
            end
            else if (pick < 62)
            begin
                s.push_back(CH_AT);
                if ($urandom_range(99) >= 5)
                    repeat ($urandom_range(1, 5))
                        s.push_back(pick_name_char());
                case ($urandom_range(0, 5))
                    0, 1: s.push_back(CH_SPACE);
                    2:    s.push_back(CH_LBRACE);
                    3:    s.push_back(CH_RBRACE);
                    4:    s.push_back(pick_text_char());
                    default: ;
                endcase
            end
            else if (pick < 76)
            begin
                s.push_back($urandom_range(1) ? CH_LBRACE : CH_RBRACE);
            end
            else if (pick < 88)
            begin
                s.push_back(CH_BACKSLASH);
                s.push_back(8'($urandom_range(255)));
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                    s.push_back(8'($urandom_range(255)));
            end
        end
        // string that ends on an escape
        if ($urandom_range(99) < 5)
            s.push_back(CH_BACKSLASH);
        return s;
    endfunction

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings
        send_string('{8'h00, 8'hFF});
        send_string('{CH_AT, "A", "z", CH_DASH, CH_UNDERLINE, CH_SPACE,
                      CH_LBRACE, "x", CH_RBRACE});
        send_string('{CH_AT, "a", "Z", CH_RBRACE});
        send_string('{CH_BACKSLASH, CH_AT, "q"});
        send_string('{CH_AT, CH_AT, "x"});
        send_string('{"a", CH_BACKSLASH});
        send_string('{CH_AT});
        send_string('{CH_AT, "b"});

        // Random strings over four idling phases
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            case (bytes_sent * 4 / RANDOM_BYTES)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 55;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 55;
                end
                default:
                begin
                    idle_pct  = 29;
                    stall_pct = 29;
                end
            endcase
            send_string(random_markup());
        end
        in_valid <= 1'b0;

        // Drain
        while (sb.pending_tokens.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (sb.errors == 0)
            $display("markup_text_tokenizer verification clean");
        else
            $display("markup_text_tokenizer verification failed");
        $finish;
    end

endmodule
